[hdl/assert_macros.svh]
// assertion helpers shared by the rtl files
// both expect signals named clk and rst_n in the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define GFFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define GFFC_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hdl/gffc_pkg.sv]
package gffc_pkg;

    localparam int IDX_W            = 6;
    localparam int MASK_W           = 64;
    localparam int COLOR_SPACE      = 64;
    localparam int LANES            = 8;
    localparam int LANE_W           = 3;
    localparam int GROUPS           = COLOR_SPACE / LANES;
    localparam int ROW_FIELD_W      = IDX_W - LANE_W;
    localparam int DEF_MAX_VERTICES = 64;
    localparam logic [IDX_W-1:0] COLOR_MAX = IDX_W'(COLOR_SPACE - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIND = 3'b100
    } gffc_state_t;

    // control from the sequencer to every lane
    typedef struct packed {
        logic                   wr_en;
        logic [LANE_W-1:0]      wr_lane;
        logic [ROW_FIELD_W-1:0] wr_row;
        logic [IDX_W-1:0]       wr_color;
        logic [ROW_FIELD_W-1:0] rd_row;
    } lane_ctrl_t;

endpackage

[hdl/gffc_in_if.sv]
interface gffc_in_if import gffc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] neighbor_mask;
    logic              final_vertex;

    modport source (output valid, output neighbor_mask, output final_vertex, input ready);
    modport sink (input valid, input neighbor_mask, input final_vertex, output ready);
endinterface

[hdl/gffc_out_if.sv]
interface gffc_out_if import gffc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] vertex_index;
    logic [IDX_W-1:0] assigned_color;
    logic             graph_done;

    modport source (output valid, output vertex_index, output assigned_color,
                    output graph_done, input ready);
    modport sink (input valid, input vertex_index, input assigned_color,
                  input graph_done, output ready);
endinterface

[hdl/gffc_lane.sv]
module gffc_lane import gffc_pkg::*; #(
    parameter int LANE_ID = 0,
    parameter int ROW_W   = 3
) (
    input  logic                   clk,
    input  lane_ctrl_t             ctrl,
    input  logic                   nbr,
    output logic [COLOR_SPACE-1:0] used
);

    localparam int BANK_DEPTH = 2 ** ROW_W;

    // colors of vertices LANE_ID, LANE_ID + LANES, ...
    logic [IDX_W-1:0] bank_reg [BANK_DEPTH];
    logic [IDX_W-1:0] rd_color;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en && ctrl.wr_lane == LANE_W'(LANE_ID))
        begin
            bank_reg[ctrl.wr_row[ROW_W-1:0]] <= ctrl.wr_color;
        end
    end

    assign rd_color = bank_reg[ctrl.rd_row[ROW_W-1:0]];

    // one-hot of the neighbor's color, empty when not a neighbor
    assign used = nbr ? (COLOR_SPACE'(1) << rd_color) : '0;

endmodule

[hdl/gffc_merge.sv]
module gffc_merge import gffc_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   clear,
    input  logic                   accum,
    input  logic [COLOR_SPACE-1:0] lane_used [LANES],
    output logic [IDX_W-1:0]       color
);

    `include "assert_macros.svh"

    logic [COLOR_SPACE-1:0] used_reg;
    logic [COLOR_SPACE-1:0] used_next;
    logic [COLOR_SPACE-1:0] row_used;
    logic [COLOR_SPACE-1:0] search;
    logic [GROUPS-1:0]      grp_zero;
    logic [LANE_W-1:0]      grp_pos [GROUPS];
    logic [LANE_W-1:0]      grp_sel;

    always_comb
    begin
        row_used = '0;
        for (int l = 0; l < LANES; l++)
        begin
            row_used = row_used | lane_used[l];
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (clear)
        begin
            used_next = '0;
        end
        else if (accum)
        begin
            used_next = used_reg | row_used;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    // top color is the fallback, so it always counts as free
    assign search = {1'b0, used_reg[COLOR_SPACE-2:0]};

    // first free color: per group of eight, then across groups
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_zero[g] = ~&search[g*LANES +: LANES];
            grp_pos[g]  = '0;
            for (int b = LANES - 1; b >= 0; b--)
            begin
                if (!search[g*LANES + b])
                begin
                    grp_pos[g] = LANE_W'(b);
                end
            end
        end
    end

    always_comb
    begin
        grp_sel = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (grp_zero[g])
            begin
                grp_sel = LANE_W'(g);
            end
        end
    end

    assign color = IDX_W'({grp_sel, grp_pos[grp_sel]});

    `GFFC_ASSERT(a_color_free, (!used_reg[color] || color == COLOR_MAX), "chosen color in use")

endmodule

[hdl/greedy_first_fit_graph_coloring.sv]
// Greedy first-fit graph coloring. Each transaction on item carries one vertex's
// adjacency row; bits at or above the vertex's own index are ignored. The vertex
// gets the lowest color held by none of its earlier neighbors, and one result
// transaction returns its index, its color and graph_done. final_vertex, or
// reaching MAX_VERTICES - 1, closes the graph and restarts numbering at zero.
// Stored colors live in eight lane banks; all eight lanes read one row of
// earlier vertices per cycle. From acceptance to the next accept, vertex n
// passes an accept step, one scan step per row of eight earlier vertices
// (rounded up to include the vertex's own row) and the free-color search and
// store. The result sits in an output register, so the next vertex is accepted
// while the previous result still waits; the search stalls while it is full.

module greedy_first_fit_graph_coloring import gffc_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic clk,
    input  logic rst_n,
    gffc_in_if.sink    item,
    gffc_out_if.source result
);

    `include "assert_macros.svh"

    localparam int ROWS  = (MAX_VERTICES + LANES - 1) / LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_VERTICES - 1);

    // sequencer state
    gffc_state_t      state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] last_row_reg, last_row_next;
    logic             out_valid_reg, out_valid_next;

    // current vertex
    logic [IDX_W-1:0]  idx_reg;
    logic [MASK_W-1:0] mask_reg;
    logic              last_reg;

    // result register
    logic [IDX_W-1:0] out_idx_reg;
    logic [IDX_W-1:0] out_color_reg;
    logic             out_done_reg;

    logic                   accept;
    logic                   find_fire;
    logic                   in_last;
    logic [MASK_W-1:0]      earlier;
    logic [IDX_W-1:0]       row_base;
    logic [LANES-1:0]       row_nbr;
    logic [IDX_W-1:0]       color;
    logic [COLOR_SPACE-1:0] lane_used [LANES];
    lane_ctrl_t             lane_ctrl;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign find_fire  = (state_reg == ST_FIND) && (!out_valid_reg || result.ready);

    // only vertices before this one in the current graph count
    assign earlier = (MASK_W'(1) << cnt_reg) - MASK_W'(1);
    assign in_last = item.final_vertex || (cnt_reg == LAST_IDX);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        row_next      = row_reg;
        last_row_next = last_row_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = ST_SCAN;
                    cnt_next      = in_last ? '0 : cnt_reg + IDX_W'(1);
                    row_next      = '0;
                    last_row_next = ROW_W'(cnt_reg >> LANE_W);
                end
            end
            ST_SCAN:
            begin
                if (row_reg == last_row_reg)
                begin
                    state_next = ST_FIND;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            ST_FIND:
            begin
                if (find_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result slot: loaded by the search, emptied by the sink
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (find_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            row_reg       <= '0;
            last_row_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            row_reg       <= row_next;
            last_row_reg  <= last_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg  <= cnt_reg;
            mask_reg <= item.neighbor_mask & earlier;
            last_reg <= in_last;
        end
        if (find_fire)
        begin
            out_idx_reg   <= idx_reg;
            out_color_reg <= color;
            out_done_reg  <= last_reg;
        end
    end

    // neighbor bits of the row being scanned, one per lane
    assign row_base = IDX_W'({row_reg, {LANE_W{1'b0}}});
    assign row_nbr  = mask_reg[row_base +: LANES];

    assign lane_ctrl.wr_en    = find_fire;
    assign lane_ctrl.wr_lane  = idx_reg[LANE_W-1:0];
    assign lane_ctrl.wr_row   = ROW_FIELD_W'(idx_reg >> LANE_W);
    assign lane_ctrl.wr_color = color;
    assign lane_ctrl.rd_row   = ROW_FIELD_W'(row_reg);

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        gffc_lane #(
            .LANE_ID (l),
            .ROW_W   (ROW_W)
        ) u_lane (
            .clk  (clk),
            .ctrl (lane_ctrl),
            .nbr  (row_nbr[l]),
            .used (lane_used[l])
        );
    end

    gffc_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (accept),
        .accum     (state_reg == ST_SCAN),
        .lane_used (lane_used),
        .color     (color)
    );

    assign result.valid          = out_valid_reg;
    assign result.vertex_index   = out_idx_reg;
    assign result.assigned_color = out_color_reg;
    assign result.graph_done     = out_done_reg;

    `GFFC_ASSERT(a_final_restarts, (accept && item.final_vertex |=> cnt_reg == '0), "counter not restarted")
    `GFFC_NEVER(a_row_overrun, (state_reg == ST_SCAN && row_reg > last_row_reg), "scan past last row")
    `GFFC_ASSERT(a_limit_done, (result.valid && result.vertex_index == LAST_IDX |-> result.graph_done), "vertex limit without graph_done")

endmodule

[dv/tb_greedy_first_fit_graph_coloring.sv]
// self-checking bench for the first-fit coloring engine: rows go in through
// one handshake channel, colors come back on the other, and every result is
// matched against a running prediction of the color table
module tb_greedy_first_fit_graph_coloring;
    import gffc_pkg::*;

    // block runs at its full vertex limit
    localparam int LIMIT_VERTICES  = DEF_MAX_VERTICES;
    // rows to send overall, random part included
    localparam int ROW_TARGET      = 1550;
    // settle time after the queue drains, padded well past the worst per-vertex time
    localparam int DRAIN_CYCLES    = 40;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int WATCHDOG_CYCLES = 1000000;
    localparam int HOLD_CYCLES     = 300;

    typedef struct packed {
        logic [IDX_W-1:0] vertex_index;
        logic [IDX_W-1:0] assigned_color;
        logic             graph_done;
    } coloring_t;

    // shapes of adjacency row used by the random part
    typedef enum int {
        ROW_RANDOM,
        ROW_DENSE,
        ROW_SPARSE,
        ROW_FULL,
        ROW_EMPTY
    } row_kind_t;

    logic clk;
    logic rst_n;

    gffc_in_if  item ();
    gffc_out_if result ();

    greedy_first_fit_graph_coloring #(
        .MAX_VERTICES(LIMIT_VERTICES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .result(result)
    );

    // predictor state: colors of the current graph and the next vertex index
    logic [IDX_W-1:0] color_table [COLOR_SPACE];
    logic [IDX_W-1:0] next_vertex;
    coloring_t        expected_colorings [$];

    int errors;
    int rows_sent;

    // idle controls, changed by the tests as they go
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold;
    int rx_wait;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // gap lengths: 85 percent from the short range, the rest from the long range
    function automatic int pick_gap();
        if ($urandom_range(99) < 85)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // first-fit rule: mark colors of earlier neighbors, take the lowest free one
    function automatic coloring_t predict_coloring(input logic [MASK_W-1:0] row,
                                                   input logic last);
        logic [IDX_W-1:0]       idx;
        logic [COLOR_SPACE-1:0] taken;
        logic [IDX_W-1:0]       pick;
        coloring_t              r;
        idx   = next_vertex;
        taken = '0;
        // diagonal and later bits never count
        for (int i = 0; i < MASK_W; i++)
            if (i < int'(idx) && row[i])
                taken[color_table[i]] = 1'b1;
        // at most 63 earlier neighbors, so the top color is the fallback
        pick = COLOR_MAX;
        for (int c = COLOR_SPACE - 2; c >= 0; c--)
            if (!taken[c])
                pick = IDX_W'(c);
        color_table[idx] = pick;
        r.vertex_index   = idx;
        r.assigned_color = pick;
        // reaching the vertex limit closes the graph even without final_vertex
        r.graph_done     = last || (int'(idx) + 1 >= LIMIT_VERTICES);
        next_vertex      = r.graph_done ? '0 : idx + 1'b1;
        return r;
    endfunction

    function automatic logic [MASK_W-1:0] random_row(input row_kind_t kind);
        logic [MASK_W-1:0] a;
        logic [MASK_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case (kind)
            ROW_DENSE:  return a | b;
            ROW_SPARSE: return a & b & {$urandom, $urandom};
            ROW_FULL:   return '1;
            ROW_EMPTY:  return '0;
            default:    return a;
        endcase
    endfunction

    function automatic row_kind_t pick_kind();
        int p;
        p = $urandom_range(99);
        if (p < 35)
            return ROW_RANDOM;
        if (p < 60)
            return ROW_DENSE;
        if (p < 85)
            return ROW_SPARSE;
        if (p < 93)
            return ROW_FULL;
        return ROW_EMPTY;
    endfunction

    // one row transaction: optional idle gap, then hold valid until accepted
    task automatic send_row(input logic [MASK_W-1:0] row, input logic last, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            item.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item.valid         <= 1'b1;
        item.neighbor_mask <= row;
        item.final_vertex  <= last;
        do
            @(posedge clk);
        while (item.ready !== 1'b1);
        expected_colorings.insert(expected_colorings.size(), predict_coloring(row, last));
        rows_sent++;
    endtask

    function automatic int tx_gap();
        return ($urandom_range(99) < tx_idle_pct) ? pick_gap() : 0;
    endfunction

    // sink side: ready decided at the falling edge
    initial
    begin
        result.ready <= 1'b0;
        rx_wait = 0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                result.ready <= 1'b0;
            else if (rx_hold > 0)
            begin
                // long hold-off so the block backs up into its input
                result.ready <= 1'b0;
                rx_hold--;
            end
            else if (rx_wait > 0)
            begin
                result.ready <= 1'b0;
                rx_wait--;
            end
            else if ($urandom_range(99) < rx_idle_pct)
            begin
                result.ready <= 1'b0;
                rx_wait = pick_gap() - 1;
            end
            else
                result.ready <= 1'b1;
        end
    end

    // result checker: every result transaction against the oldest prediction
    initial
    begin
        coloring_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result.valid === 1'b1 && result.ready === 1'b1)
            begin
                if (expected_colorings.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual idx %0d color %0d done %0b",
                             $time, result.vertex_index, result.assigned_color,
                             result.graph_done);
                    errors++;
                end
                else
                begin
                    want = expected_colorings.pop_front();
                    if (result.vertex_index !== want.vertex_index)
                    begin
                        $display("%0t vertex_index: expected %0d actual %0d",
                                 $time, want.vertex_index, result.vertex_index);
                        errors++;
                    end
                    if (result.assigned_color !== want.assigned_color)
                    begin
                        $display("%0t assigned_color (vertex %0d): expected %0d actual %0d",
                                 $time, want.vertex_index, want.assigned_color,
                                 result.assigned_color);
                        errors++;
                    end
                    if (result.graph_done !== want.graph_done)
                    begin
                        $display("%0t graph_done (vertex %0d): expected %0b actual %0b",
                                 $time, want.vertex_index, want.graph_done,
                                 result.graph_done);
                        errors++;
                    end
                end
            end
        end
    end

    // a lone vertex gets color zero whatever its row says
    task automatic test_first_vertex();
        send_row('1, 1'b1, 0);
        send_row('0, 1'b1, 2);
        send_row({$urandom, $urandom}, 1'b1, 0);
    endtask

    // bits at the vertex's own index and above must be ignored
    task automatic test_ignored_bits();
        send_row('1, 1'b0, 0);
        send_row(~64'h1, 1'b0, 0);                   // only the diagonal and above
        send_row('1, 1'b0, 1);                       // both earlier vertices hold color 0
        send_row(64'hFFFF_FFFF_FFFF_FFF8, 1'b0, 0); // nothing below index 3
        send_row(64'h8000_0000_0000_0006, 1'b1, 0); // neighbors 1 and 2, top bit stale
    endtask

    // free color found in a hole below the highest taken color
    task automatic test_color_hole();
        send_row('0, 1'b0, 0);
        send_row(64'h1, 1'b0, 0);  // color 1
        send_row(64'h3, 1'b0, 0);  // color 2
        send_row(64'h2, 1'b0, 3);  // only vertex 1 -> color 0
        send_row(64'hE, 1'b0, 0);  // colors 1, 2, 0 taken -> 3
        send_row(64'h16, 1'b0, 0); // colors 1, 2, 3 -> 0
        send_row(64'h1D, 1'b1, 0); // colors 0, 2, 0, 3 -> 1
    endtask

    // a full clique climbs to color 63 and the limit closes the graph on its own
    task automatic test_vertex_limit();
        for (int v = 0; v < LIMIT_VERTICES; v++)
            send_row('1, 1'b0, 0);
        // numbering has restarted, so this is vertex zero again
        send_row('1, 1'b1, 0);
    endtask

    // receiver holds off while rows keep coming, filling the block up
    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        rx_hold     = HOLD_CYCLES;
        for (int v = 0; v < 40; v++)
            send_row(random_row(pick_kind()), v == 39, 0);
    endtask

    // random graphs: mostly small, some near the limit, some that run past it
    task automatic test_random_graphs();
        int        len;
        int        p;
        logic      noisy;
        logic      last;
        row_kind_t kind;
        while (rows_sent < ROW_TARGET)
        begin
            // change the idle profile per graph, with idle-free stretches too
            tx_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 5);
            rx_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 5);
            p = $urandom_range(99);
            if (p < 65)
                len = $urandom_range(10, 1);
            else if (p < 85)
                len = $urandom_range(40, 11);
            else if (p < 95)
                len = $urandom_range(LIMIT_VERTICES, 41);
            else
                len = $urandom_range(LIMIT_VERTICES + 16, LIMIT_VERTICES + 1);
            // a few graphs carry a stray final_vertex in the middle
            noisy = ($urandom_range(9) == 0);
            kind  = pick_kind();
            for (int v = 0; v < len; v++)
            begin
                if (len > LIMIT_VERTICES)
                    last = 1'b0;
                else if (noisy)
                    last = (v == len - 1) || ($urandom_range(7) == 0);
                else
                    last = (v == len - 1);
                // mostly one row shape per graph, sometimes mixed
                if ($urandom_range(4) == 0)
                    kind = pick_kind();
                send_row(random_row(kind), last, tx_gap());
            end
        end
    endtask

    initial
    begin
        int waited;
        errors      = 0;
        rows_sent   = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold     = 0;
        next_vertex = '0;
        for (int i = 0; i < COLOR_SPACE; i++)
            color_table[i] = '0;
        rst_n              <= 1'b0;
        item.valid         <= 1'b0;
        item.neighbor_mask <= '0;
        item.final_vertex  <= 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_first_vertex();
        rx_idle_pct = 30;
        tx_idle_pct = 30;
        test_ignored_bits();
        test_color_hole();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_vertex_limit();
        test_output_backpressure();
        test_random_graphs();

        @(negedge clk);
        item.valid  <= 1'b0;
        rx_idle_pct = 0;

        // drain, then let the pipeline settle to catch any stray result
        waited = 0;
        while (expected_colorings.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_colorings.size() != 0)
        begin
            $display("%0t results missing: expected %0d more, actual 0",
                     $time, expected_colorings.size());
            errors++;
        end

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // hard stop in case the handshake hangs
    initial
    begin
        repeat (WATCHDOG_CYCLES) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

endmodule
